[sv/pca_pkg.sv]
// pca_pkg: widths, types and helper functions for the polygon area and convexity block
// no dependencies; imported by the design modules, polygon_area_monitor and tb_top
package pca_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int COORD_BITS   = 16;
  localparam int AREA_W       = 48;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int EPROD_W      = 2 * COORD_BITS;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int TPROD_W      = 2 * DIFF_W;
  localparam int NUM_TURNS    = 3;
  localparam int MIN_POLY     = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [EPROD_W-1:0]    eprod_t;
  typedef logic signed [TPROD_W-1:0]    tprod_t;
  typedef logic signed [AREA_W-1:0]     area_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_e;

  // one pending turn test: cross = lhs - rhs
  typedef struct packed {
    logic   valid;
    tprod_t lhs;
    tprod_t rhs;
  } turn_t;

  typedef struct packed {
    dir_e dir;
    logic rev;
  } orient_t;

  function automatic diff_t sub_ext(input coord_t a, input coord_t b);
    sub_ext = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  function automatic eprod_t mul_c(input coord_t a, input coord_t b);
    mul_c = a * b;
  endfunction

  function automatic tprod_t mul_d(input diff_t a, input diff_t b);
    mul_d = a * b;
  endfunction

  // difference of a pair of edge products, sign extended to the accumulator width
  function automatic area_t edge_term(input eprod_t a, input eprod_t b);
    logic signed [EPROD_W:0] d;
    d = {a[EPROD_W-1], a} - {b[EPROD_W-1], b};
    edge_term = AREA_W'(d);
  endfunction

endpackage

[sv/pca_orient.sv]
// pca_orient: folds up to three turn signs, in order, into the direction and reversal state
// depends on pca_pkg
module pca_orient import pca_pkg::*; (
  input  turn_t [NUM_TURNS-1:0] turns_i,
  input  orient_t               state_i,
  output orient_t               state_o
);

  always_comb begin
    orient_t                 st;
    logic signed [TPROD_W:0] cross_w;
    dir_e                    d;
    st = state_i;
    for (int i = 0; i < NUM_TURNS; i++) begin
      cross_w = {turns_i[i].lhs[TPROD_W-1], turns_i[i].lhs}
              - {turns_i[i].rhs[TPROD_W-1], turns_i[i].rhs};
      d = cross_w[TPROD_W] ? DIR_NEG : DIR_POS;
      // straight turns leave the state alone
      if (turns_i[i].valid && (cross_w != '0)) begin
        case (st.dir)
          DIR_POS, DIR_NEG: begin
            if (st.dir != d) st.rev = 1'b1;
          end
          default: begin
            st.dir = d;
          end
        endcase
      end
    end
    state_o = st;
  end

endmodule

[sv/polygon_convexity_and_area.sv]
// polygon_convexity_and_area: shoelace area and convexity test over a vertex stream
// depends on pca_pkg and pca_orient
//
//   channel   handshake                 payload
//   in        in_valid_i / in_ready_o   x_coord_i, y_coord_i, last_vertex_i
//   out       out_valid_o / out_ready_i double_area_o, is_convex_o, vertex_count_o
//
// one vertex per cycle unless stalled; a last vertex passes the input register and the
// product register, and its result is then held in the result register
// reset clears the pipeline valids, the vertex count and the area and turn state
// while a result waits, ordinary vertices keep flowing; a last vertex holds in the
// product stage until the result register is free, and the input stalls behind it
module polygon_convexity_and_area import pca_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [COORD_BITS-1:0] x_coord_i,
  input  logic [COORD_BITS-1:0] y_coord_i,
  input  logic                last_vertex_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [AREA_W-1:0]   double_area_o,
  output logic                is_convex_o,
  output logic [CNT_W-1:0]    vertex_count_o
);

  localparam cnt_t CNT_MAX  = CNT_W'(MAX_VERTICES);
  localparam cnt_t CNT_POLY = CNT_W'(MIN_POLY);

  // input register
  logic   s1_valid_q;
  coord_t s1_x_q, s1_y_q;
  logic   s1_last_q;

  // vertex history
  coord_t first_x_q, first_y_q, second_x_q, second_y_q;
  coord_t older_x_q, older_y_q, newer_x_q, newer_y_q;
  cnt_t   cnt_q;

  // product register
  logic   s2_valid_q, s2_last_q, s2_edge_q, s2_close_q;
  eprod_t ea1_q, ea2_q, eb1_q, eb2_q;
  turn_t [NUM_TURNS-1:0] turns_q;
  cnt_t   s2_n_q;

  // accumulation state
  area_t   acc_q;
  orient_t orient_q;

  // result register
  logic       out_valid_q;
  area_t      area_q;
  logic       convex_q;
  cnt_t       out_cnt_q;

  logic    in_fire, s1_ready, s1_fire, s2_ready, s2_go, out_space;
  cnt_t    n_d;
  diff_t   d_on, d_pn, d_fp, d_sf;
  diff_t   dy_on, dy_pn, dy_fp, dy_sf;
  area_t   acc_new;
  orient_t orient_new;

  assign out_space = !out_valid_q || out_ready_i;
  assign s2_go     = s2_valid_q && (!s2_last_q || out_space);
  assign s2_ready  = !s2_valid_q || s2_go;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign s1_fire   = s1_valid_q && s2_ready;
  assign in_ready_o = s1_ready;
  assign in_fire   = in_valid_i && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q    <= coord_t'(x_coord_i);
      s1_y_q    <= coord_t'(y_coord_i);
      s1_last_q <= last_vertex_i;
    end
  end

  assign n_d = (cnt_q >= CNT_MAX) ? CNT_MAX : cnt_q + cnt_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (s1_fire) begin
      cnt_q <= s1_last_q ? '0 : n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      if (cnt_q == '0) begin
        first_x_q <= s1_x_q;
        first_y_q <= s1_y_q;
      end
      if (cnt_q == cnt_t'(1)) begin
        second_x_q <= s1_x_q;
        second_y_q <= s1_y_q;
      end
      older_x_q <= newer_x_q;
      older_y_q <= newer_y_q;
      newer_x_q <= s1_x_q;
      newer_y_q <= s1_y_q;
    end
  end

  // edge vectors: older to newer, newer to new point, new point to first, first to second
  assign d_on  = sub_ext(newer_x_q, older_x_q);
  assign dy_on = sub_ext(newer_y_q, older_y_q);
  assign d_pn  = sub_ext(s1_x_q, newer_x_q);
  assign dy_pn = sub_ext(s1_y_q, newer_y_q);
  assign d_fp  = sub_ext(first_x_q, s1_x_q);
  assign dy_fp = sub_ext(first_y_q, s1_y_q);
  assign d_sf  = sub_ext(second_x_q, first_x_q);
  assign dy_sf = sub_ext(second_y_q, first_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_fire) begin
      s2_valid_q <= 1'b1;
    end else if (s2_go) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_last_q  <= s1_last_q;
      s2_n_q     <= n_d;
      s2_edge_q  <= (cnt_q != '0);
      s2_close_q <= s1_last_q && (n_d >= CNT_POLY);
      ea1_q      <= mul_c(newer_x_q, s1_y_q);
      ea2_q      <= mul_c(s1_x_q, newer_y_q);
      eb1_q      <= mul_c(s1_x_q, first_y_q);
      eb2_q      <= mul_c(first_x_q, s1_y_q);
      // turn at the newer vertex
      turns_q[0].valid <= (cnt_q >= cnt_t'(2));
      turns_q[0].lhs   <= mul_d(d_on, dy_pn);
      turns_q[0].rhs   <= mul_d(dy_on, d_pn);
      // wrap-around turns at the last and the first vertex
      turns_q[1].valid <= s1_last_q && (n_d >= CNT_POLY);
      turns_q[1].lhs   <= mul_d(d_pn, dy_fp);
      turns_q[1].rhs   <= mul_d(dy_pn, d_fp);
      turns_q[2].valid <= s1_last_q && (n_d >= CNT_POLY);
      turns_q[2].lhs   <= mul_d(d_fp, dy_sf);
      turns_q[2].rhs   <= mul_d(dy_fp, d_sf);
    end
  end

  assign acc_new = acc_q
                 + (s2_edge_q  ? edge_term(ea1_q, ea2_q) : area_t'(0))
                 + (s2_close_q ? edge_term(eb1_q, eb2_q) : area_t'(0));

  pca_orient u_orient (
    .turns_i (turns_q),
    .state_i (orient_q),
    .state_o (orient_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      orient_q.dir <= DIR_NONE;
      orient_q.rev <= 1'b0;
    end else if (s2_go) begin
      if (s2_last_q) begin
        acc_q        <= '0;
        orient_q.dir <= DIR_NONE;
        orient_q.rev <= 1'b0;
      end else begin
        acc_q    <= acc_new;
        orient_q <= orient_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_go && s2_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && s2_last_q) begin
      area_q    <= (s2_n_q < CNT_POLY) ? area_t'(0) : acc_new;
      convex_q  <= (s2_n_q <= CNT_POLY) ? 1'b1 : !orient_new.rev;
      out_cnt_q <= s2_n_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign double_area_o  = area_q;
  assign is_convex_o    = convex_q;
  assign vertex_count_o = out_cnt_q;

  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> cnt_q == '0)
    else $error("vertex count not cleared after last vertex");

  a_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_go && s2_last_q |=> acc_q == '0 && orient_q.dir == DIR_NONE && !orient_q.rev)
    else $error("area or turn state not cleared after result");

  a_small_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vertex_count_o < CNT_POLY |-> double_area_o == '0)
    else $error("nonzero area below three vertices");

  a_small_convex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vertex_count_o <= CNT_POLY |-> is_convex_o)
    else $error("small polygon reported non-convex");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> vertex_count_o != '0 && vertex_count_o <= CNT_MAX)
    else $error("vertex count out of range");

endmodule

[sim/polygon_area_monitor.sv]
`timescale 1ns / 100ps
// polygon_area_monitor: watches both channels of polygon_convexity_and_area, predicts
// each polygon result from the accepted vertices and compares it; depends on pca_pkg
module polygon_area_monitor import pca_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   in_ready_i,
  input  coord_t x_coord_i,
  input  coord_t y_coord_i,
  input  logic   last_vertex_i,
  input  logic   out_valid_i,
  input  logic   out_ready_i,
  input  area_t  double_area_i,
  input  logic   is_convex_i,
  input  cnt_t   vertex_count_i,
  output int     awaited_o,
  output int     errors_o
);

  typedef struct packed {
    area_t area;
    logic  convex;
    cnt_t  count;
  } poly_result_t;

  poly_result_t awaited_q[$];

  coord_t first_x, first_y, second_x, second_y;
  coord_t older_x, older_y, newer_x, newer_y;
  area_t  shoelace;
  dir_e   winding;
  logic   reversed;
  cnt_t   seen;
  int     fail_count = 0;
  int     awaited_count = 0;

  assign errors_o  = fail_count;
  assign awaited_o = awaited_count;

  function automatic area_t cross_term(input coord_t ax, ay, bx, by);
    longint t;
    t = longint'(ax) * longint'(by) - longint'(bx) * longint'(ay);
    return area_t'(t);
  endfunction

  // sign of the turn a -> b -> c; zero crosses leave the winding alone
  function automatic void note_turn(input coord_t ax, ay, bx, by, cx, cy);
    longint cr;
    dir_e   d;
    cr = (longint'(bx) - longint'(ax)) * (longint'(cy) - longint'(by))
       - (longint'(by) - longint'(ay)) * (longint'(cx) - longint'(bx));
    if (cr != 0) begin
      d = (cr < 0) ? DIR_NEG : DIR_POS;
      if (winding == DIR_NONE) winding = d;
      else if (winding != d) reversed = 1'b1;
    end
  endfunction

  function automatic void clear_polygon();
    first_x = '0; first_y = '0; second_x = '0; second_y = '0;
    older_x = '0; older_y = '0; newer_x = '0; newer_y = '0;
    shoelace = '0;
    winding  = DIR_NONE;
    reversed = 1'b0;
    seen     = '0;
  endfunction

  function automatic void take_vertex(input coord_t x, y, input logic last);
    poly_result_t r;
    if (seen == 0) begin
      first_x = x;
      first_y = y;
    end else begin
      if (seen == 1) begin
        second_x = x;
        second_y = y;
      end
      shoelace = shoelace + cross_term(newer_x, newer_y, x, y);
      if (seen >= 2) note_turn(older_x, older_y, newer_x, newer_y, x, y);
    end
    older_x = newer_x;
    older_y = newer_y;
    newer_x = x;
    newer_y = y;
    if (seen < MAX_VERTICES) seen = seen + 1'b1;
    if (last) begin
      // close the ring back through the first two vertices
      if (seen >= MIN_POLY) begin
        shoelace = shoelace + cross_term(x, y, first_x, first_y);
        note_turn(older_x, older_y, x, y, first_x, first_y);
        note_turn(x, y, first_x, first_y, second_x, second_y);
      end
      r.area   = (seen < MIN_POLY) ? area_t'(0) : shoelace;
      r.convex = (seen <= MIN_POLY) ? 1'b1 : !reversed;
      r.count  = seen;
      awaited_q.insert(awaited_q.size(), r);
      clear_polygon();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    poly_result_t exp_r;
    if (!rst_ni) begin
      awaited_q.delete();
      clear_polygon();
    end else begin
      // results are checked before this edge's request can add a new expectation
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result area=%0d convex=%0b count=%0d", $time,
                     $signed(double_area_i), is_convex_i, vertex_count_i);
        end else begin
          exp_r = awaited_q.pop_front();
          if (exp_r.area !== double_area_i || exp_r.convex !== is_convex_i ||
              exp_r.count !== vertex_count_i) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp area=%0d convex=%0b count=%0d",
                       $time, $signed(exp_r.area), exp_r.convex, exp_r.count,
                       ", got area=%0d convex=%0b count=%0d",
                       $signed(double_area_i), is_convex_i, vertex_count_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) take_vertex(x_coord_i, y_coord_i, last_vertex_i);
    end
    awaited_count = awaited_q.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: vertex stimulus and verdict for polygon_convexity_and_area
// depends on pca_pkg, the block itself and polygon_area_monitor
module tb_top;
  import pca_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  coord_t x_coord_i = '0;
  coord_t y_coord_i = '0;
  logic   last_vertex_i = 1'b0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  area_t  double_area_o;
  logic   is_convex_o;
  cnt_t   vertex_count_o;

  int      stall_pct = 11;
  int      items_sent = 0;
  int      awaited;
  int      errors;
  vertex_t poly_q[$];

  polygon_convexity_and_area DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .last_vertex_i  (last_vertex_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .double_area_o  (double_area_o),
    .is_convex_o    (is_convex_o),
    .vertex_count_o (vertex_count_o)
  );

  polygon_area_monitor u_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .last_vertex_i  (last_vertex_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .double_area_i  (double_area_o),
    .is_convex_i    (is_convex_o),
    .vertex_count_i (vertex_count_o),
    .awaited_o      (awaited),
    .errors_o       (errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_vertex(input coord_t x, y, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < stall_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    x_coord_i     <= x;
    y_coord_i     <= y;
    last_vertex_i <= last;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_polygon();
    foreach (poly_q[i]) send_vertex(poly_q[i].x, poly_q[i].y, i == poly_q.size() - 1);
    poly_q.delete();
  endtask

  task automatic add_vertex(input int x, y);
    vertex_t v;
    v.x = coord_t'(x);
    v.y = coord_t'(y);
    poly_q.insert(poly_q.size(), v);
  endtask

  function automatic coord_t pick_coord(input int span);
    coord_t edge_vals[6];
    edge_vals = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    case (span)
      0:       return coord_t'($urandom);
      1:       return coord_t'(int'($urandom_range(8)) - 4);
      2:       return coord_t'(int'($urandom_range(200)) - 100);
      default: return edge_vals[$urandom_range(5)];
    endcase
  endfunction

  // convex ring round an axis-aligned box, with collinear points on the sides
  task automatic build_box(input int span);
    coord_t  a, b, xl, xh, yl, yh;
    vertex_t corner[4];
    vertex_t v;
    int      extra;
    bit      clockwise;
    longint  dx, dy;
    a  = pick_coord(span);
    b  = pick_coord(span);
    xl = (a < b) ? a : b;
    xh = (a < b) ? b : a;
    a  = pick_coord(span);
    b  = pick_coord(span);
    yl = (a < b) ? a : b;
    yh = (a < b) ? b : a;
    corner[0] = '{xl, yl};
    corner[1] = '{xh, yl};
    corner[2] = '{xh, yh};
    corner[3] = '{xl, yh};
    clockwise = $urandom_range(1);
    for (int s = 0; s < 4; s++) begin
      extra = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
      dx = longint'(corner[(s + 1) % 4].x) - longint'(corner[s].x);
      dy = longint'(corner[(s + 1) % 4].y) - longint'(corner[s].y);
      for (int j = 0; j <= extra; j++) begin
        v.x = coord_t'(longint'(corner[s].x) + dx * j / (extra + 1));
        v.y = coord_t'(longint'(corner[s].y) + dy * j / (extra + 1));
        if (clockwise) poly_q.push_front(v);
        else poly_q.insert(poly_q.size(), v);
      end
    end
  endtask

  task automatic build_scatter(input int span, input int max_len);
    int      len;
    vertex_t v;
    len = $urandom_range(1, max_len);
    repeat (len) begin
      v.x = pick_coord(span);
      v.y = pick_coord(span);
      poly_q.insert(poly_q.size(), v);
    end
  endtask

  initial begin
    int      base;
    int      pick;
    vertex_t vtx;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // lone vertex and a two-vertex segment: no area, always convex
    add_vertex(32767, -32768);
    send_polygon();
    add_vertex(-32768, 32767);
    add_vertex(0, 0);
    send_polygon();
    // clockwise triangle
    add_vertex(0, 0);
    add_vertex(0, 10);
    add_vertex(10, 0);
    send_polygon();
    // full-range square, anticlockwise then clockwise
    add_vertex(-32768, -32768);
    add_vertex(32767, -32768);
    add_vertex(32767, 32767);
    add_vertex(-32768, 32767);
    send_polygon();
    add_vertex(-32768, -32768);
    add_vertex(-32768, 32767);
    add_vertex(32767, 32767);
    add_vertex(32767, -32768);
    send_polygon();
    // dented quadrilateral
    add_vertex(0, 0);
    add_vertex(10, 0);
    add_vertex(2, 2);
    add_vertex(0, 10);
    send_polygon();
    // collinear points give zero turns
    add_vertex(0, 0);
    add_vertex(5, 0);
    add_vertex(10, 0);
    add_vertex(10, 10);
    add_vertex(0, 10);
    send_polygon();

    // one polygon long enough to saturate the vertex count
    repeat (4100) begin
      vtx.x = pick_coord(0);
      vtx.y = pick_coord(0);
      poly_q.insert(poly_q.size(), vtx);
    end
    send_polygon();

    base = items_sent;
    while (items_sent - base < 1850) begin
      stall_pct = (items_sent - base >= 700 && items_sent - base < 1100) ? 0 : 11;
      pick = $urandom_range(99);
      if (pick < 40) build_box(($urandom_range(1) == 0) ? 0 : 2);
      else if (pick < 70) build_scatter(0, 10);
      else if (pick < 85) build_scatter(1, 8);
      else build_scatter(3, ($urandom_range(19) == 0) ? 60 : 16);
      send_polygon();
    end
    stall_pct = 11;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
